/* sv/assert_macros.svh */
// Assertion helpers used by the decoder sequencer (thd_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define THD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("decoder check failed: next-cycle property");

// Check that the consequent holds in the same cycle as the antecedent.
`define THD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decoder check failed: same-cycle property");

`endif

/* sv/thd_pkg.sv */
// ----------------------------------------------------------------------------
// thd_pkg
// Shared sizes, codes and controller/datapath signal groups of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package thd_pkg;

   localparam int SYMBOL_DEPTH = 256;
   localparam int INDEX_DEPTH  = 64;
   localparam int MAX_STEPS    = 32;

   localparam int SYM_AW    = $clog2(SYMBOL_DEPTH);
   localparam int IDX_AW    = $clog2(INDEX_DEPTH);
   localparam int STEP_W    = $clog2(MAX_STEPS);
   // running length bound: max_code_len plus one 4-bit step per iteration
   localparam int BOUND_MAX = 31 + 15 * MAX_STEPS;
   localparam int BOUND_W   = $clog2(BOUND_MAX + 1);

   localparam int MAX_LEN_RESET = 16;

   typedef enum logic [1:0] {
      FUNC_WR_SYM = 2'd0,
      FUNC_WR_IDX = 2'd1,
      FUNC_DECODE = 2'd2
   } func_type;

   typedef struct packed {
      logic req_ready;
      logic sym_we;
      logic idx_we;
      logic load_win;
      logic count;
      logic idx_rd;
      logic sym_rd_ent;
      logic latch_sym;
      logic step_adv;
      logic latch_base;
      logic sym_rd_fin;
      logic out_ok;
      logic out_err;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       scan_full;
      logic       at_oob;
      logic       base_oob;
      logic       pre_gt;
      logic       off_under;
      logic       steps_last;
      logic       out_busy;
   } status_type;

endpackage

`default_nettype wire

/* sv/thd_req_if.sv */
// ----------------------------------------------------------------------------
// thd_req_if
// Request channel: table writes and decode windows, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface thd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  table_addr;
   logic [31:0] table_word;
   logic [31:0] bit_window;

   modport source (output valid, func, table_addr, table_word, bit_window, input ready);
   modport sink   (input valid, func, table_addr, table_word, bit_window, output ready);
endinterface

`default_nettype wire

/* sv/thd_rsp_if.sv */
// ----------------------------------------------------------------------------
// thd_rsp_if
// Response channel: decoded symbol, code length and error flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface thd_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] symbol_index;
   logic [4:0]  code_length;
   logic        decode_error;

   modport source (output valid, symbol_index, code_length, decode_error, input ready);
   modport sink   (input valid, symbol_index, code_length, decode_error, output ready);
endinterface

`default_nettype wire

/* sv/thd_ram.sv */
// ----------------------------------------------------------------------------
// thd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module thd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

/* sv/thd_dpath.sv */
// ----------------------------------------------------------------------------
// thd_dpath
// Decoder datapath: table RAMs, window scan, step arithmetic, response regs.
// ----------------------------------------------------------------------------
`default_nettype none

module thd_dpath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire thd_pkg::cmd_type     cmd,
   output thd_pkg::status_type       st,
   input  wire logic [1:0]           req_func,
   input  wire logic [7:0]           req_table_addr,
   input  wire logic [31:0]          req_table_word,
   input  wire logic [31:0]          req_bit_window,
   input  wire logic                 csr_we,
   input  wire logic [4:0]           csr_wdata,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic [10:0]               rsp_symbol_index,
   output logic [4:0]                rsp_code_length,
   output logic                      rsp_decode_error
);

   logic [4:0]                    max_len_ff;
   logic                          rsp_valid_ff;
   logic [31:0]                   loc_ff;
   logic [31:0]                   scan_ff;
   logic [thd_pkg::BOUND_W-1:0]   at_ff;
   logic [thd_pkg::BOUND_W-1:0]   bound_ff;
   logic [thd_pkg::STEP_W-1:0]    steps_ff;
   logic [30:0]                   pre_ff;
   logic [4:0]                    len_ff;
   logic [7:0]                    base_ff;
   logic [10:0]                   rsp_sym_ff;
   logic [4:0]                    rsp_len_ff;
   logic                          rsp_err_ff;

   logic [31:0]                   loc_in;
   logic [3:0]                    lead;
   logic [15:0]                   sym_rdata;
   logic [31:0]                   idx_rdata;
   logic [3:0]                    ent_step;
   logic [7:0]                    ent_base;
   logic [19:0]                   ent_cw;
   logic [31:0]                   pre_full;
   logic [19:0]                   diff;
   logic [7:0]                    base_new;
   logic [thd_pkg::BOUND_W-1:0]   bound_in;
   logic [8:0]                    sym_raddr_full;
   logic                          sym_we;
   logic                          idx_we;

   // count leading ones of a byte, MSB first
   function automatic logic [3:0] lead_ones8(input logic [7:0] b);
      logic [3:0] n;
      logic       run;
      n   = 4'd0;
      run = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         run = run & b[i];
         n   = n + 4'(run);
      end
      return n;
   endfunction

   always_comb begin
      loc_in         = req_bit_window & ~(32'hFFFF_FFFF >> max_len_ff);
      lead           = lead_ones8(scan_ff[31:24]);
      ent_step       = idx_rdata[31:28];
      ent_base       = idx_rdata[27:20];
      ent_cw         = idx_rdata[19:0];
      // prefix of len bits; a zero length shifts everything out
      pre_full       = {1'b0, loc_ff[31:1]} >> (5'd31 - sym_rdata[4:0]);
      diff           = ent_cw - pre_ff[19:0];
      base_new       = ent_base - diff[7:0];
      bound_in       = bound_ff + thd_pkg::BOUND_W'(ent_step);
      sym_raddr_full = cmd.sym_rd_fin ? ({1'b0, base_ff} + 9'd1) : ({1'b0, ent_base} + 9'd1);
      sym_we         = cmd.sym_we && (32'(req_table_addr) < 32'(thd_pkg::SYMBOL_DEPTH));
      idx_we         = cmd.idx_we && (32'(req_table_addr) < 32'(thd_pkg::INDEX_DEPTH));
   end

   thd_ram #(
      .WIDTH (16),
      .DEPTH (thd_pkg::SYMBOL_DEPTH)
   ) u_sym_ram (
      .clock (clock),
      .we    (sym_we),
      .waddr (req_table_addr[thd_pkg::SYM_AW-1:0]),
      .wdata (req_table_word[15:0]),
      .re    (cmd.sym_rd_ent || cmd.sym_rd_fin),
      .raddr (sym_raddr_full[thd_pkg::SYM_AW-1:0]),
      .rdata (sym_rdata)
   );

   thd_ram #(
      .WIDTH (32),
      .DEPTH (thd_pkg::INDEX_DEPTH)
   ) u_idx_ram (
      .clock (clock),
      .we    (idx_we),
      .waddr (req_table_addr[thd_pkg::IDX_AW-1:0]),
      .wdata (req_table_word),
      .re    (cmd.idx_rd),
      .raddr (at_ff[thd_pkg::IDX_AW-1:0]),
      .rdata (idx_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= 5'(thd_pkg::MAX_LEN_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            max_len_ff <= csr_wdata;
         end
         if (cmd.out_ok || cmd.out_err) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_win) begin
         loc_ff   <= loc_in;
         scan_ff  <= {loc_in[30:0], 1'b0};
         at_ff    <= '0;
         bound_ff <= thd_pkg::BOUND_W'(max_len_ff);
         steps_ff <= '0;
      end
      if (cmd.count) begin
         if (&scan_ff[31:24]) begin
            at_ff   <= at_ff + thd_pkg::BOUND_W'(8);
            scan_ff <= {scan_ff[23:0], 8'h00};
         end else begin
            at_ff <= at_ff + thd_pkg::BOUND_W'(lead);
         end
      end
      if (cmd.latch_sym) begin
         len_ff <= sym_rdata[4:0];
         pre_ff <= pre_full[30:0];
      end
      if (cmd.step_adv) begin
         bound_ff <= bound_in;
         at_ff    <= bound_in;
         steps_ff <= steps_ff + thd_pkg::STEP_W'(1);
      end
      if (cmd.latch_base) begin
         base_ff <= base_new;
      end
      if (cmd.out_ok) begin
         rsp_sym_ff <= sym_rdata[15:5];
         rsp_len_ff <= len_ff;
         rsp_err_ff <= 1'b0;
      end else if (cmd.out_err) begin
         rsp_sym_ff <= '0;
         rsp_len_ff <= '0;
         rsp_err_ff <= 1'b1;
      end
   end

   always_comb begin
      st.func       = req_func;
      st.scan_full  = &scan_ff[31:24];
      st.at_oob     = 32'(at_ff) >= 32'(thd_pkg::INDEX_DEPTH);
      st.base_oob   = (32'(ent_base) + 32'd1) >= 32'(thd_pkg::SYMBOL_DEPTH);
      st.pre_gt     = pre_ff > {11'd0, ent_cw};
      st.off_under  = diff > {12'd0, ent_base};
      st.steps_last = steps_ff == thd_pkg::STEP_W'(thd_pkg::MAX_STEPS - 1);
      st.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol_index = rsp_sym_ff;
   assign rsp_code_length  = rsp_len_ff;
   assign rsp_decode_error = rsp_err_ff;

endmodule

`default_nettype wire

/* sv/thd_ctrl.sv */
// ----------------------------------------------------------------------------
// thd_ctrl
// Decoder sequencer: accepts transactions and walks the index/symbol steps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module thd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire thd_pkg::status_type st,
   output thd_pkg::cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COUNT,
      ST_IDX,
      ST_ENT,
      ST_SYM,
      ST_CMP,
      ST_FIN,
      ST_DONE,
      ST_ERR
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_valid) begin
               unique case (st.func)
                  thd_pkg::FUNC_WR_SYM: cmd.sym_we = 1'b1;
                  thd_pkg::FUNC_WR_IDX: cmd.idx_we = 1'b1;
                  thd_pkg::FUNC_DECODE: begin
                     cmd.load_win = 1'b1;
                     state_in     = ST_COUNT;
                  end
                  default: ;
               endcase
            end
         end
         ST_COUNT: begin
            cmd.count = 1'b1;
            if (!st.scan_full) begin
               state_in = ST_IDX;
            end
         end
         ST_IDX: begin
            if (st.at_oob) begin
               state_in = ST_ERR;
            end else begin
               cmd.idx_rd = 1'b1;
               state_in   = ST_ENT;
            end
         end
         ST_ENT: begin
            if (st.base_oob) begin
               state_in = ST_ERR;
            end else begin
               cmd.sym_rd_ent = 1'b1;
               state_in       = ST_SYM;
            end
         end
         ST_SYM: begin
            cmd.latch_sym = 1'b1;
            state_in      = ST_CMP;
         end
         ST_CMP: begin
            if (st.pre_gt) begin
               if (st.steps_last) begin
                  state_in = ST_ERR;
               end else begin
                  cmd.step_adv = 1'b1;
                  state_in     = ST_IDX;
               end
            end else if (st.off_under) begin
               state_in = ST_ERR;
            end else begin
               cmd.latch_base = 1'b1;
               state_in       = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.sym_rd_fin = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (!st.out_busy) begin
               cmd.out_ok = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (!st.out_busy) begin
               cmd.out_err = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `THD_ASSERT_NEXT(a_decode_starts, clock, reset, state_ff == ST_IDLE && req_valid && st.func == thd_pkg::FUNC_DECODE, state_ff == ST_COUNT)
   `THD_ASSERT_NEXT(a_result_returns, clock, reset, (state_ff == ST_DONE || state_ff == ST_ERR) && !st.out_busy, state_ff == ST_IDLE)
   `THD_ASSERT_NEXT(a_step_limit, clock, reset, state_ff == ST_CMP && st.pre_gt && st.steps_last, state_ff == ST_ERR)
   `THD_ASSERT_NOW(a_fin_after_cmp, clock, reset, state_ff == ST_FIN, $past(state_ff) == ST_CMP)

endmodule

`default_nettype wire

/* sv/table_huffman_decoder_top.sv */
// ----------------------------------------------------------------------------
// table_huffman_decoder_top
// Table-driven Huffman codeword decoder with loadable symbol and index tables.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one transaction per valid/ready handshake. func 0 writes
//   symbol entry table_addr (low 16 bits of table_word), func 1 writes index
//   entry table_addr, func 2 decodes the left-aligned window bit_window.
//   Writes give no response; func 3 is dropped.
//   rsp_ch returns one transaction per decode: symbol_index, code_length and
//   decode_error (symbol and length are zero on error).
//   csr_we/csr_wdata load max_code_len; write it only while the block idles.
//   Sequence: a decode first scans the window, one byte of the leading-ones
//   run per cycle, then walks n index steps. Each step is one index RAM read
//   followed by a dependent symbol RAM read and a compare; a decode is
//   accepted only once the previous one has its result registered.
//   A stalled receiver holds the result in the output register; the next
//   transaction is still accepted and runs until its own result is ready.
//   Reset clears the sequencer and output valid and sets max_code_len to 16;
//   table contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module table_huffman_decoder_top (
   input  wire logic clock,
   input  wire logic reset,
   thd_req_if.sink   req_ch,
   thd_rsp_if.source rsp_ch,
   input  wire logic       csr_we,
   input  wire logic [4:0] csr_wdata
);

   // command and status groups between sequencer and datapath
   thd_pkg::cmd_type    cmd;
   thd_pkg::status_type st;

   thd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .st        (st),
      .cmd       (cmd)
   );

   thd_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_func         (req_ch.func),
      .req_table_addr   (req_ch.table_addr),
      .req_table_word   (req_ch.table_word),
      .req_bit_window   (req_ch.bit_window),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_symbol_index (rsp_ch.symbol_index),
      .rsp_code_length  (rsp_ch.code_length),
      .rsp_decode_error (rsp_ch.decode_error)
   );

   // accept only while the sequencer idles
   assign req_ch.ready = cmd.req_ready;

endmodule

`default_nettype wire

/* bench/thd_decode_checker.sv */
// ----------------------------------------------------------------------------
// thd_decode_checker
// Watches the request, response and CSR ports of the Huffman decoder. It keeps
// its own copy of both tables and of max_code_len, works out each decode
// result at acceptance, and compares the responses with those results in order.
// ----------------------------------------------------------------------------

module thd_decode_checker (
   input  logic       clock,
   input  logic       reset,
   thd_req_if         req_ch,
   thd_rsp_if         rsp_ch,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata,
   output int         fail_count,
   output int         pending,
   output int         error_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [10:0] symbol_index;
      logic [4:0]  code_length;
      logic        decode_error;
   } codeword_type;

   logic [15:0]  symbols [thd_pkg::SYMBOL_DEPTH];
   logic [31:0]  index_entries [thd_pkg::INDEX_DEPTH];
   logic [4:0]   code_len_limit = 5'(thd_pkg::MAX_LEN_RESET);
   codeword_type pending_codes [$];
   int           mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Walk the index table for one window and return the decoded codeword.
   function automatic codeword_type predict_codeword(input logic [31:0] window);
      logic [31:0]  masked;
      logic [31:0]  entry;
      logic [15:0]  hit;
      int unsigned  at;
      int unsigned  bound;
      int unsigned  base;
      int unsigned  len;
      int unsigned  last_cw;
      int unsigned  prefix;
      bit           found;
      bit           failed;
      codeword_type res;
      masked = window & ~(32'hffff_ffff >> code_len_limit);
      at     = 0;
      while (at < 31 && masked[30 - at]) at++;
      bound  = code_len_limit;
      found  = 1'b0;
      failed = 1'b0;
      base   = 0;
      len    = 0;
      for (int hop = 0; hop < thd_pkg::MAX_STEPS; hop++) begin
         if (at >= thd_pkg::INDEX_DEPTH) begin
            failed = 1'b1;
            break;
         end
         entry = index_entries[at];
         base  = entry[27:20];
         if (base + 1 >= thd_pkg::SYMBOL_DEPTH) begin
            failed = 1'b1;
            break;
         end
         len     = symbols[base + 1][4:0];
         last_cw = entry[19:0];
         prefix  = (len == 0) ? 0 : masked >> (32 - len);
         if (prefix > last_cw) begin
            bound += entry[31:28];
            at     = bound;
         end else begin
            if (last_cw - prefix > base) begin
               failed = 1'b1;
               break;
            end
            base -= last_cw - prefix;
            found = 1'b1;
            break;
         end
      end
      res = '0;
      if (found && !failed) begin
         hit              = symbols[base + 1];
         res.symbol_index = hit[15:5];
         res.code_length  = 5'(len);
      end else begin
         res.decode_error = 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      codeword_type want;
      codeword_type got;
      if (reset) begin
         code_len_limit = 5'(thd_pkg::MAX_LEN_RESET);
         pending_codes.delete();
      end else begin
         if (csr_we) code_len_limit = csr_wdata;
         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.func)
               thd_pkg::FUNC_WR_SYM: begin
                  symbols[req_ch.table_addr] = req_ch.table_word[15:0];
               end
               thd_pkg::FUNC_WR_IDX: begin
                  // addresses past the index table are dropped
                  if (req_ch.table_addr < thd_pkg::INDEX_DEPTH)
                     index_entries[req_ch.table_addr] = req_ch.table_word;
               end
               thd_pkg::FUNC_DECODE: begin
                  want = predict_codeword(req_ch.bit_window);
                  pending_codes.push_back(want);
                  if (want.decode_error) error_results++;
               end
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.symbol_index, rsp_ch.code_length, rsp_ch.decode_error};
            if (pending_codes.size() == 0) begin
               report_mismatch($sformatf("response sym=%0d len=%0d err=%0b with no decode open",
                                         got.symbol_index, got.code_length, got.decode_error));
            end else begin
               want = pending_codes.pop_front();
               if (got.symbol_index !== want.symbol_index)
                  report_mismatch($sformatf("symbol_index %0d, expected %0d",
                                            got.symbol_index, want.symbol_index));
               if (got.code_length !== want.code_length)
                  report_mismatch($sformatf("code_length %0d, expected %0d",
                                            got.code_length, want.code_length));
               if (got.decode_error !== want.decode_error)
                  report_mismatch($sformatf("decode_error %0b, expected %0b",
                                            got.decode_error, want.decode_error));
            end
         end
      end
      pending = pending_codes.size();
   end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the table-driven Huffman decoder: loads both tables in full, runs a
// short set of hand-built walks (every error path, zero lengths, mask edges),
// then random phases of table writes and decodes under several max_code_len
// values, with random idle bursts on both channels. The checker does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT   = 1_500_000;
   localparam int         SETTLE_CYCLES = 12;
   localparam int         RANDOM_ITEMS  = 1120;
   localparam int         PHASES        = 8;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       csr_we    = 1'b0;
   logic [4:0] csr_wdata = '0;

   thd_req_if req_ch ();
   thd_rsp_if rsp_ch ();

   int fail_count;
   int pending;
   int error_results;

   // stimulus-side image of the symbol table, used to aim decode walks
   logic [15:0] sym_img [thd_pkg::SYMBOL_DEPTH];
   logic [4:0]  len_limit = 5'(thd_pkg::MAX_LEN_RESET);

   bit req_gaps   = 1'b1;
   bit rsp_stalls = 1'b1;
   int items_done    = 0;
   int decodes_done  = 0;
   int settings_used = 0;
   int cycles        = 0;

   table_huffman_decoder_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   thd_decode_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .error_results (error_results)
   );

   always #6 clock = ~clock;

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still open", cycles, pending);
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Response side: hold ready high, drop it for random bursts while stalls are on.
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_stalls && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // Keep only the top len bits of a window.
   function automatic logic [31:0] window_mask(input logic [4:0] len);
      return ~(32'hffff_ffff >> len);
   endfunction

   function automatic int unsigned lead_ones(input logic [31:0] v);
      int unsigned n;
      n = 0;
      while (n < 31 && v[30 - n]) n++;
      return n;
   endfunction

   // Symbol entry with a code length biased toward short codes.
   function automatic logic [31:0] symbol_word();
      logic [31:0] w;
      int          pick;
      w    = $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 7) w[4:0] = 5'($urandom_range(1, 12));
      else if (pick < 9) w[4:0] = 5'($urandom_range(13, 20));
      return w;
   endfunction

   // Window with a random run of ones from bit 30 most of the time, so that
   // the first index address spreads over the whole range.
   function automatic logic [31:0] pick_window();
      logic [31:0] w;
      int          run;
      w = $urandom;
      if ($urandom_range(0, 2) != 0) begin
         run = $urandom_range(0, 31);
         for (int b = 30; b >= 0 && b > 30 - run; b--) w[b] = 1'b1;
         if (run <= 30) w[30 - run] = 1'b0;
      end
      return w;
   endfunction

   // Present one transaction and wait for it to be taken. Enter and leave at a
   // falling edge; valid stays high into the next call unless a gap comes.
   task automatic push_item(input logic [1:0] func, input logic [7:0] addr,
                            input logic [31:0] word, input logic [31:0] window);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.func       <= func;
      req_ch.table_addr <= addr;
      req_ch.table_word <= word;
      req_ch.bit_window <= window;
      do @(posedge clock); while (!req_ch.ready);
      if (func == thd_pkg::FUNC_DECODE) decodes_done++;
      // ignored transactions do not count as work
      if (func == thd_pkg::FUNC_WR_SYM || func == thd_pkg::FUNC_DECODE ||
          (func == thd_pkg::FUNC_WR_IDX && addr < thd_pkg::INDEX_DEPTH))
         items_done++;
      @(negedge clock);
   endtask

   task automatic write_sym(input logic [7:0] addr, input logic [31:0] word);
      sym_img[addr] = word[15:0];
      push_item(thd_pkg::FUNC_WR_SYM, addr, word, $urandom);
   endtask

   task automatic write_idx(input logic [7:0] addr, input logic [31:0] word);
      push_item(thd_pkg::FUNC_WR_IDX, addr, word, $urandom);
   endtask

   task automatic send_decode(input logic [31:0] window);
      push_item(thd_pkg::FUNC_DECODE, 8'($urandom), $urandom, window);
   endtask

   // Drop valid and wait until every open decode has answered, then give the
   // block a few more cycles to finish any trailing table write.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_len_limit(input logic [4:0] v);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      len_limit  = v;
      settings_used++;
   endtask

   // Rewrite the index entries on this window's path so that it steps past
   // the given number of entries and then lands on a symbol, then decode it.
   task automatic send_walk(input logic [31:0] window, input int hops);
      logic [31:0] masked;
      logic [7:0]  base_sel;
      logic [3:0]  stride;
      int unsigned at;
      int unsigned bound;
      int unsigned len;
      int unsigned prefix;
      int unsigned cw;
      int          tries;
      masked = window & window_mask(len_limit);
      at     = lead_ones(masked);
      bound  = len_limit;
      for (int h = 0; h <= hops; h++) begin
         tries = 0;
         // hunt for a base whose code length suits the planned move
         do begin
            base_sel = 8'($urandom_range(0, 254));
            len      = sym_img[base_sel + 1][4:0];
            prefix   = (len == 0) ? 0 : masked >> (32 - len);
            tries++;
         end while (tries < 8 && ((h < hops) ? prefix == 0 : prefix > 32'hf_ffff));
         if (h < hops && prefix != 0) begin
            // prefix above the last codeword: advance the length bound
            cw     = $urandom % ((prefix > 32'hf_ffff) ? 32'h10_0000 : prefix);
            stride = 4'($urandom_range(1, 15));
            write_idx(8'(at), {stride, base_sel, 20'(cw)});
            bound += stride;
            at     = bound;
            if (at >= thd_pkg::INDEX_DEPTH) break;
         end else begin
            cw = prefix + $urandom_range(0, base_sel);
            if (cw > 32'hf_ffff) cw = 32'hf_ffff;
            write_idx(8'(at), {4'($urandom), base_sel, 20'(cw)});
            break;
         end
      end
      send_decode(window);
   endtask

   // Mostly aimed walks with random content; the rest is table churn, blind
   // decodes, ignored transactions and an occasional full drain.
   task automatic run_phase(input int count);
      int start;
      int sel;
      int hops;
      start = items_done;
      while (items_done - start < count) begin
         sel = $urandom_range(0, 99);
         if (sel < 65) begin
            hops = $urandom_range(0, 19);
            hops = (hops < 10) ? 0 : (hops < 16) ? 1 :
                   (hops < 19) ? $urandom_range(2, 3) : $urandom_range(4, 8);
            send_walk(pick_window(), hops);
         end else if (sel < 80) begin
            write_sym(8'($urandom), symbol_word());
         end else if (sel < 90) begin
            send_decode(pick_window());
         end else if (sel < 94) begin
            write_idx(8'($urandom), $urandom);
         end else if (sel < 97) begin
            push_item(FUNC_UNUSED, 8'($urandom), $urandom, $urandom);
         end else begin
            settle();
         end
      end
   endtask

   initial begin
      logic [4:0] phase_len [PHASES];
      req_ch.valid      = 1'b0;
      req_ch.func       = thd_pkg::FUNC_WR_SYM;
      req_ch.table_addr = '0;
      req_ch.table_word = '0;
      req_ch.bit_window = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Load both tables in full so that no decode can touch an unwritten entry.
      for (int a = 0; a < thd_pkg::SYMBOL_DEPTH; a++) write_sym(8'(a), symbol_word());
      for (int a = 0; a < thd_pkg::INDEX_DEPTH; a++) write_idx(8'(a), $urandom);

      // Ignored transactions: unused func, index addresses past the table.
      push_item(FUNC_UNUSED, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
      write_idx(8'hff, 32'h0);
      write_idx(8'(thd_pkg::INDEX_DEPTH), 32'hffff_ffff);

      // Longest run of ones the reset mask allows.
      send_walk(32'hffff_ffff, 0);

      // Base at the last symbol entry: symbol out of range.
      write_idx(8'd0, 32'hffff_ffff);
      send_decode(32'h0000_0000);

      // Zero code length, all-ones symbol index.
      write_sym(8'd1, 32'h0000_ffe0);
      write_idx(8'd0, 32'h0000_0000);
      send_decode(32'h0000_0000);

      // Codeword two past the prefix with base 1: offset underflow.
      write_sym(8'd2, 32'h0000_5544);
      write_idx(8'd0, 32'h0010_000a);
      send_decode(32'h8000_0000);

      set_len_limit(5'd31);

      // Steps of 15 from 31 run off the index table.
      write_sym(8'd1, 32'h0000_2abf);
      write_idx(8'd0, 32'hf000_0000);
      write_idx(8'd46, 32'hf000_0000);
      write_idx(8'd61, 32'hf000_0000);
      send_decode(32'h8000_0000);

      // Zero step that never matches: step limit.
      write_idx(8'd0, 32'h0000_0000);
      write_idx(8'd31, 32'h0000_0000);
      send_decode(32'h8000_0000);

      // Deepest first address with a short multi-step walk.
      send_walk(32'h7fff_ffff, 2);

      // Zero mask: window reads as zero, hits the 31-bit code at entry 1.
      set_len_limit(5'd0);
      send_decode(pick_window());

      set_len_limit(5'd1);
      send_walk(pick_window(), 1);

      // Random phases; the last one runs without idling on either side.
      phase_len = '{5'd12, 5'd31, 5'd1, 5'd0, 5'($urandom_range(1, 31)),
                    5'($urandom_range(1, 31)), 5'd16, 5'($urandom_range(2, 30))};
      for (int p = 0; p < PHASES; p++) begin
         set_len_limit(phase_len[p]);
         req_gaps   = (p != 2 && p != 5 && p != PHASES - 1);
         rsp_stalls = (p != 1 && p != 5 && p != PHASES - 1);
         run_phase(RANDOM_ITEMS / PHASES);
      end

      // Drain and leave time for any stray response to show up.
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      $display("covered %0d transactions, %0d decodes (%0d expected to fail)",
               items_done, decodes_done, error_results);
      $display("max_code_len written %0d times, including 0, 1 and 31", settings_used);
      if (fail_count == 0 && pending == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
